// File: hdl/isort_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isort_pkg
// Shared codes and the command/status bundles between the sorter's
// controller and datapath.
// ----------------------------------------------------------------------------
package isort_pkg;

    // Command field of an input item (s_tuser)
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_DRAIN  = 1'b1;

    // Flag positions in the result item's m_tuser
    localparam int USER_EMPTY_BIT = 0;
    localparam int USER_OVF_BIT   = 1;
    localparam int USER_BITS      = 2;

    // Controller to datapath
    typedef struct packed {
        logic capture;     // latch the accepted item
        logic ins_direct;  // write value at the fill position, grow the store
        logic ins_start;   // read the tail entry, start the shift walk
        logic step_shift;  // move the compared entry one slot back
        logic place;       // write value at the walk index, grow the store
        logic drain_rd;    // read the entry at the drain position
        logic load_ovf;    // present an overflow result
        logic load_empty;  // present an empty result
        logic load_drain;  // present the drained value, advance
    } isort_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic cmd_drain;   // latched item is a drain
        logic full;        // no room for another insert
        logic empty;       // nothing left to drain
        logic has_above;   // undrained entries exist below the fill position
        logic greater;     // new value beats the entry just read
        logic more_left;   // another undrained entry lies below the walk index
        logic out_free;    // output register can take a result
    } isort_sts_t;

endpackage

// File: hdl/isort_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isort_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module isort_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hdl/isort_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isort_ctrl
// Sequencer for the sorter: decodes each item, walks the insertion shift
// one entry per cycle and hands results to the output register.
// ----------------------------------------------------------------------------
module isort_ctrl
    import isort_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  isort_sts_t sts,
    output isort_cmd_t cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_COMPARE,
        ST_PLACE,
        ST_DRAIN_RD,
        ST_EMIT_OVF,
        ST_EMIT_EMPTY,
        ST_EMIT_DRAIN
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.capture = s_tvalid;
                if (s_tvalid)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                if (sts.cmd_drain)
                begin
                    if (sts.empty)
                    begin
                        state_next = ST_EMIT_EMPTY;
                    end
                    else
                    begin
                        cmd.drain_rd = 1'b1;
                        state_next   = ST_DRAIN_RD;
                    end
                end
                else if (sts.full)
                begin
                    state_next = ST_EMIT_OVF;
                end
                else if (sts.has_above)
                begin
                    cmd.ins_start = 1'b1;
                    state_next    = ST_COMPARE;
                end
                else
                begin
                    cmd.ins_direct = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_COMPARE:
            begin
                if (sts.greater)
                begin
                    cmd.step_shift = 1'b1;
                    if (!sts.more_left)
                    begin
                        state_next = ST_PLACE;
                    end
                end
                else
                begin
                    cmd.place  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_PLACE:
            begin
                cmd.place  = 1'b1;
                state_next = ST_IDLE;
            end
            ST_DRAIN_RD:
            begin
                state_next = ST_EMIT_DRAIN;
            end
            ST_EMIT_OVF:
            begin
                if (sts.out_free)
                begin
                    cmd.load_ovf = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_EMIT_EMPTY:
            begin
                if (sts.out_free)
                begin
                    cmd.load_empty = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_EMIT_DRAIN:
            begin
                if (sts.out_free)
                begin
                    cmd.load_drain = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

endmodule

// File: hdl/isort_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isort_dp
// Sorter datapath: item latch, fill and drain counters, shift-walk index,
// sorted store RAM and the result register.
// ----------------------------------------------------------------------------
module isort_dp
    import isort_pkg::*;
#(
    parameter int DEPTH      = 1024,
    parameter int VALUE_BITS = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [31:0]          s_tdata,
    input  logic                 s_tuser,
    input  logic                 m_tready,
    output logic                 m_tvalid,
    output logic [31:0]          m_tdata,
    output logic                 m_tlast,
    output logic [USER_BITS-1:0] m_tuser,
    input  isort_cmd_t           cmd,
    output isort_sts_t           sts
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [VALUE_BITS-1:0] val_reg;
    logic                  kind_reg;
    logic [CW-1:0]         fill_reg;
    logic [CW-1:0]         drain_reg;
    logic [AW-1:0]         idx_reg;

    logic                  m_tvalid_reg;
    logic [31:0]           m_tdata_reg;
    logic                  m_tlast_reg;
    logic [USER_BITS-1:0]  m_tuser_reg;
    logic [USER_BITS-1:0]  m_tuser_next;

    logic [63:0]            in_wide;
    logic [31+VALUE_BITS:0] out_wide;
    logic [VALUE_BITS-1:0]  rd_data;
    logic [AW-1:0]          idx_m1;
    logic [AW-1:0]          idx_m2;
    logic [CW-1:0]          fill_m1;
    logic [CW-1:0]          drain_p1;
    logic                   is_last;

    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [VALUE_BITS-1:0] ram_wdata;
    logic                  ram_re;
    logic [AW-1:0]         ram_raddr;

    assign in_wide  = {{32{s_tdata[31]}}, s_tdata};
    assign out_wide = {{32{rd_data[VALUE_BITS-1]}}, rd_data};
    assign idx_m1   = idx_reg - AW'(1);
    assign idx_m2   = idx_reg - AW'(2);
    assign fill_m1  = fill_reg - CW'(1);
    assign drain_p1 = drain_reg + CW'(1);
    assign is_last  = (drain_p1 == fill_reg);

    // Store port steering
    assign ram_we    = cmd.ins_direct | cmd.step_shift | cmd.place;
    assign ram_waddr = cmd.ins_direct ? fill_reg[AW-1:0] : idx_reg;
    assign ram_wdata = cmd.step_shift ? rd_data : val_reg;
    assign ram_re    = cmd.ins_start | cmd.step_shift | cmd.drain_rd;

    always_comb
    begin
        if (cmd.ins_start)
        begin
            ram_raddr = fill_m1[AW-1:0];
        end
        else if (cmd.step_shift)
        begin
            ram_raddr = idx_m2;
        end
        else
        begin
            ram_raddr = drain_reg[AW-1:0];
        end
    end

    isort_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (rd_data)
    );

    // Payload latch, no reset needed
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            val_reg  <= in_wide[VALUE_BITS-1:0];
            kind_reg <= s_tuser;
        end
        if (cmd.ins_start)
        begin
            idx_reg <= fill_reg[AW-1:0];
        end
        else if (cmd.step_shift)
        begin
            idx_reg <= idx_m1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg  <= '0;
            drain_reg <= '0;
        end
        else if (cmd.ins_direct || cmd.place)
        begin
            fill_reg <= fill_reg + CW'(1);
        end
        else if (cmd.load_drain)
        begin
            // Last value out empties the store
            if (is_last)
            begin
                fill_reg  <= '0;
                drain_reg <= '0;
            end
            else
            begin
                drain_reg <= drain_p1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (cmd.load_ovf || cmd.load_empty || cmd.load_drain)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_comb
    begin
        m_tuser_next                 = '0;
        m_tuser_next[USER_EMPTY_BIT] = cmd.load_empty;
        m_tuser_next[USER_OVF_BIT]   = cmd.load_ovf;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_ovf || cmd.load_empty || cmd.load_drain)
        begin
            m_tdata_reg <= cmd.load_drain ? out_wide[31:0] : 32'd0;
            m_tlast_reg <= cmd.load_drain & is_last;
            m_tuser_reg <= m_tuser_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

    assign sts.cmd_drain = (kind_reg == CMD_DRAIN);
    assign sts.full      = (fill_reg == CW'(DEPTH));
    assign sts.empty     = (drain_reg >= fill_reg);
    assign sts.has_above = (fill_reg > drain_reg);
    assign sts.greater   = ($signed(val_reg) > $signed(rd_data));
    assign sts.more_left = (CW'(idx_m1) > drain_reg);
    assign sts.out_free  = !m_tvalid_reg || m_tready;

    // Every insert write (direct or placed) grows the fill count by exactly one entry
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.ins_direct || cmd.place) |=> fill_reg == $past(fill_reg) + CW'(1))
        else $error("fill count did not advance after an insert");

    // Drain pointer stays below the fill count unless the store is empty
    assert property (@(posedge clk) disable iff (!rst_n)
        (drain_reg < fill_reg) || (drain_reg == '0 && fill_reg == '0))
        else $error("drain position ran past the fill count");

    // A result carries at most one of last, empty and overflow
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid_reg |-> $countones({m_tlast_reg, m_tuser_reg}) <= 1)
        else $error("result flags conflict");

    // A drain result shows up in the output register next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_drain |=> m_tvalid_reg && !m_tuser_reg[USER_EMPTY_BIT])
        else $error("drain result lost");

endmodule

// File: hdl/insertion_sorter.sv
`timescale 1ns / 1ps
// Inserts: an insert into an empty store is written straight at the fill position after decode;
//   any other insert shifts back each smaller entry it moves past, on the RAM's two ports, then places its value.
// A drain or a rejected insert loads its result after decode (a drain after its store read), later if
//   the output register is still held by an earlier result.
// One item is in work at a time; s_tready returns once the item's work is done.
// Reset (rst_n low, asynchronous) empties the store at once; no clearing pass.
// ----------------------------------------------------------------------------
// insertion_sorter
// Descending insertion sorter over a RAM store: inserts signed values,
// drains them largest first, flags overflow and empty drains.
// ----------------------------------------------------------------------------
module insertion_sorter
    import isort_pkg::*;
#(
    parameter int DEPTH      = 1024,
    parameter int VALUE_BITS = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [31:0]          s_tdata,   // [31:0] value
    input  logic                 s_tuser,   // [0] command
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [31:0]          m_tdata,   // [31:0] sorted_value
    output logic                 m_tlast,
    output logic [USER_BITS-1:0] m_tuser    // [0] empty_res, [1] overflow
);

    isort_cmd_t cmd;
    isort_sts_t sts;

    isort_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    isort_dp #(
        .DEPTH      (DEPTH),
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .cmd      (cmd),
        .sts      (sts)
    );

endmodule
